// ===== sv/acbc_pkg.sv =====
// Shared types, constants and GF/S-box functions for the AES-128 CBC cipher.
package acbc_pkg;

    localparam int NumRounds = 10;
    localparam int KeyDepth  = 2 * (NumRounds + 1);
    localparam int KeyAw     = 5;

    localparam logic [2:0] CfgMode   = 3'd0;
    localparam logic [2:0] CfgKeyHi  = 3'd1;
    localparam logic [2:0] CfgKeyLo  = 3'd2;
    localparam logic [2:0] CfgIvHi   = 3'd3;
    localparam logic [2:0] CfgIvLo   = 3'd4;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic       start;
        logic       inv;
        logic       first;
        logic       last;
    } t_rnd_ctl;

    localparam logic [7:0] FwdSub [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] RevSub [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    localparam logic [7:0] RoundConst [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FwdSub[w[31:24]], FwdSub[w[23:16]], FwdSub[w[15:8]], FwdSub[w[7:0]]};
    endfunction

endpackage

// ===== sv/aes128_cbc_block_cipher.sv =====
// AES-128 CBC block cipher top level: registers, key expansion and round sequencer.
//
// Usage: write decrypt_mode, key and IV through the plain write port (index =
// register number) while the block is idle. Send 128-bit blocks on the input
// channel (i_valid / o_stall); set i_first_block on the first block of each
// message. Results appear on the output channel (o_valid / i_stall).
// A first block expands the eleven round keys first, one word per cycle through
// a single S-box word unit, into a 22-entry RAM.
// Each block then runs one key read setup, eleven steps (whitening add and ten
// rounds) on one shared round unit fed one half round key per cycle from the
// RAM, and a load of the result register.
// The input is stalled while a block is in work. The next block may be
// accepted in the cycle after the result is loaded.
// The result register holds until taken; a new result waits in the round unit
// while the previous one is held, which keeps the input stalled.
// Reset clears the configuration registers, the chain value and the sequencer;
// the round key RAM is undefined until the first block of a message.
module aes128_cbc_block_cipher
    import acbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic        i_first_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_high,
    output logic [63:0] o_out_low
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StKey  = 3'd1;
    localparam logic [2:0] StLd   = 3'd2;
    localparam logic [2:0] StRnd  = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;

    logic        r_mode;
    logic [63:0] r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    t_block      r_chain;
    t_block      r_blk;
    t_block      r_res;
    logic        r_inv;
    logic [2:0]  r_st;
    logic [5:0]  r_cnt;
    logic [31:0] r_w [4];
    logic [3:0]  r_rc;
    logic [31:0] r_wlo;
    logic [63:0] r_kbuf;
    logic        r_kph;

    logic        w_acc;
    logic        w_we;
    logic        w_res_load;
    logic [KeyAw-1:0] w_waddr, w_raddr;
    logic [63:0] w_wdata, w_rdata;
    logic [31:0] w_t, w_new;
    logic [3:0]  w_rnd_next;
    t_rnd_ctl    w_ctl;
    t_block      w_state, w_load;

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = r_st != StIdle;

    // Key schedule: one word per cycle; cnt counts words 0..43, pass the key words first.
    always_comb begin
        w_t = r_w[3];
        if (r_cnt[1:0] == 2'd0) begin
            w_t = sub_word({r_w[3][23:0], r_w[3][31:24]}) ^ {RoundConst[r_rc], 24'h0};
        end
        if (r_cnt[5:2] == 4'd0) begin
            w_new = r_w[0];
        end else begin
            w_new = r_w[0] ^ w_t;
        end
    end

    assign w_we    = (r_st == StKey) && r_cnt[0];
    assign w_waddr = r_cnt[KeyAw:1];
    assign w_wdata = {r_wlo, w_new};

    // Round key reads: high half of the current round, then low half, read ahead of use.
    assign w_rnd_next = r_inv ? r_cnt[3:0] - 4'd1 : r_cnt[3:0] + 4'd1;
    always_comb begin
        if (r_st != StRnd) begin
            w_raddr = {r_inv ? 4'(NumRounds) : 4'd0, 1'b0};
        end else if (!r_kph) begin
            w_raddr = {r_cnt[3:0], 1'b1};
        end else if (w_ctl.last) begin
            w_raddr = '0;
        end else begin
            w_raddr = {w_rnd_next, 1'b0};
        end
    end

    acbc_ram #(.Width(64), .Depth(KeyDepth), .Aw(KeyAw)) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_load = r_inv ? r_blk : (r_blk ^ r_chain);
    always_comb begin
        w_ctl.start = (r_st == StRnd) && r_kph && (r_cnt == 6'(r_inv ? NumRounds : 0));
        w_ctl.first = (r_st == StRnd) && r_kph && !w_ctl.start;
        w_ctl.inv   = r_inv;
        w_ctl.last  = r_inv ? (r_cnt == 6'd0) : (r_cnt == 6'(NumRounds));
    end

    assign w_res_load = (r_st == StOut) && (!o_valid || !i_stall);

    acbc_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_load  (w_load),
        .i_key   ({r_kbuf, w_rdata}),
        .o_state (w_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_iv_hi <= '0;
            r_iv_lo <= '0;
            r_chain <= '0;
            r_st    <= StIdle;
            r_cnt   <= '0;
            r_kph   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgMode:  r_mode   <= i_cfg_data[0];
                    CfgKeyHi: r_key_hi <= i_cfg_data;
                    CfgKeyLo: r_key_lo <= i_cfg_data;
                    CfgIvHi:  r_iv_hi  <= i_cfg_data;
                    CfgIvLo:  r_iv_lo  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_res_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_st)
                StIdle: begin
                    if (w_acc) begin
                        r_blk <= {i_block_high, i_block_low};
                        r_inv <= r_mode;
                        if (i_first_block) begin
                            r_chain <= {r_iv_hi, r_iv_lo};
                            r_w[0] <= r_key_hi[63:32];
                            r_w[1] <= r_key_hi[31:0];
                            r_w[2] <= r_key_lo[63:32];
                            r_w[3] <= r_key_lo[31:0];
                            r_cnt  <= 6'd0;
                            r_rc   <= '0;
                            r_st   <= StKey;
                        end else begin
                            r_st <= StLd;
                        end
                    end
                end
                StKey: begin
                    r_w[0] <= r_w[1];
                    r_w[1] <= r_w[2];
                    r_w[2] <= r_w[3];
                    r_w[3] <= w_new;
                    r_wlo  <= w_new;
                    if (r_cnt[1:0] == 2'd0 && r_cnt[5:2] != 4'd0) begin
                        r_rc <= r_rc + 4'd1;
                    end
                    if (r_cnt == 6'd43) begin
                        r_st <= StLd;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                StLd: begin
                    r_cnt <= r_inv ? 6'(NumRounds) : 6'd0;
                    r_kph <= 1'b0;
                    r_st  <= StRnd;
                end
                StRnd: begin
                    r_kph <= !r_kph;
                    if (!r_kph) begin
                        r_kbuf <= w_rdata;
                    end else begin
                        if (w_ctl.last && !w_ctl.start) begin
                            r_st <= StOut;
                        end else begin
                            r_cnt <= r_inv ? r_cnt - 6'd1 : r_cnt + 6'd1;
                        end
                    end
                end
                StOut: begin
                    if (w_res_load) begin
                        r_res   <= r_inv ? (w_state ^ r_chain) : w_state;
                        r_chain <= r_inv ? r_blk : w_state;
                        r_st    <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
    end

    assign o_out_high = r_res[127:64];
    assign o_out_low  = r_res[63:0];
endmodule

// ===== sv/acbc_ram.sv =====
// Generic single-port-write RAM with registered read.
module acbc_ram #(
    parameter int Width = 64,
    parameter int Depth = 22,
    parameter int Aw    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [Aw-1:0]    i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [Aw-1:0]    i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/acbc_round.sv =====
// Shared AES round unit: initial key add or one forward/inverse round into the state register when enabled.
module acbc_round
    import acbc_pkg::*;
(
    input  logic     i_clk,
    input  t_rnd_ctl i_ctl,
    input  t_block   i_load,
    input  t_block   i_key,
    output t_block   o_state
);
    t_block r_state;
    t_block n_state;
    t_block w_ss;
    t_block w_mix;
    t_block w_fwd;
    t_block w_inv;

    always_comb begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;
        logic [7:0] m [16];
        int src;
        for (int i = 0; i < 16; i++) begin
            s[i] = r_state[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = i_ctl.inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                t[r+4*c] = i_ctl.inv ? RevSub[s[r+4*src]] : FwdSub[s[r+4*src]];
            end
        end
        for (int i = 0; i < 16; i++) begin
            w_ss[127-8*i -: 8] = t[i];
        end
        w_fwd = w_ss ^ i_key;
        for (int i = 0; i < 16; i++) begin
            s[i] = i_ctl.inv ? w_fwd[127-8*i -: 8] : t[i];
        end
        for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
            if (i_ctl.inv) begin
                // 0e,0b,0d,09 via x, x^2, x^3
                m[4*c]   = (x0^y0^xtime(y0)) ^ (a1^x1^xtime(y1)) ^ (a2^y2^xtime(y2))
                         ^ (a3^xtime(y3));
                m[4*c+1] = (x1^y1^xtime(y1)) ^ (a2^x2^xtime(y2)) ^ (a3^y3^xtime(y3))
                         ^ (a0^xtime(y0));
                m[4*c+2] = (x2^y2^xtime(y2)) ^ (a3^x3^xtime(y3)) ^ (a0^y0^xtime(y0))
                         ^ (a1^xtime(y1));
                m[4*c+3] = (x3^y3^xtime(y3)) ^ (a0^x0^xtime(y0)) ^ (a1^y1^xtime(y1))
                         ^ (a2^xtime(y2));
            end else begin
                m[4*c]   = x0 ^ (x1^a1) ^ a2 ^ a3;
                m[4*c+1] = x1 ^ (x2^a2) ^ a3 ^ a0;
                m[4*c+2] = x2 ^ (x3^a3) ^ a0 ^ a1;
                m[4*c+3] = x3 ^ (x0^a0) ^ a1 ^ a2;
            end
        end
        for (int i = 0; i < 16; i++) begin
            w_mix[127-8*i -: 8] = m[i];
        end
        if (i_ctl.inv) begin
            w_inv = i_ctl.last ? w_fwd : w_mix;
        end else begin
            w_inv = (i_ctl.last ? w_ss : w_mix) ^ i_key;
        end
        if (i_ctl.start) begin
            n_state = i_load ^ i_key;
        end else begin
            n_state = w_inv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start || i_ctl.first) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
endmodule
